FILE: sv/sbt_pkg.sv
// ----------------------------------------------------------------------------
// sbt_pkg: shared types and constants for the source byte tokenizer
// Token kinds, scanner modes, queue entry layout and the keyword compare.
// ----------------------------------------------------------------------------
package sbt_pkg;

  localparam int unsigned TokWidth    = 16;
  localparam int unsigned PrefixDepth = 6;
  localparam int unsigned QDepth      = 4;

  localparam logic [TokWidth-1:0] LenMax = '1;

  localparam logic [7:0] ChUnderscore = 8'h5F;
  localparam logic [7:0] ChEqual      = 8'h3D;

  typedef enum logic [4:0] {
    TK_EOF       = 5'd0,
    TK_LET       = 5'd1,
    TK_MUT       = 5'd2,
    TK_IF        = 5'd3,
    TK_ELSE      = 5'd4,
    TK_ELIF      = 5'd5,
    TK_UNSAFE    = 5'd6,
    TK_TYPE      = 5'd7,
    TK_IDENT     = 5'd8,
    TK_NUMBER    = 5'd9,
    TK_LBRACE    = 5'd10,
    TK_RBRACE    = 5'd11,
    TK_EQ        = 5'd12,
    TK_ASSIGN    = 5'd13,
    TK_COLON     = 5'd14,
    TK_SEMICOLON = 5'd15,
    TK_PLUS      = 5'd16,
    TK_MINUS     = 5'd17,
    TK_STAR      = 5'd18,
    TK_SLASH     = 5'd19,
    TK_GT        = 5'd20,
    TK_UNKNOWN   = 5'd21
  } tok_kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_EQ     = 2'd3
  } scan_mode_e;

  typedef logic [PrefixDepth-1:0][7:0] prefix_t;

  typedef struct packed {
    tok_kind_e           kind;
    logic [TokWidth-1:0] start;
    logic [TokWidth-1:0] length;
  } token_t;

  // One queue entry carries all tokens caused by one byte
  typedef struct packed {
    token_t first;
    token_t second;
    logic   two;
  } entry_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == ChUnderscore;
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic tok_kind_e single_kind(input logic [7:0] c);
    tok_kind_e k;
    unique case (c)
      "{":     k = TK_LBRACE;
      "}":     k = TK_RBRACE;
      ":":     k = TK_COLON;
      ";":     k = TK_SEMICOLON;
      "+":     k = TK_PLUS;
      "-":     k = TK_MINUS;
      "*":     k = TK_STAR;
      "/":     k = TK_SLASH;
      ">":     k = TK_GT;
      default: k = TK_UNKNOWN;
    endcase
    return k;
  endfunction

  // Classify a finished identifier: keyword, type name or plain identifier
  function automatic tok_kind_e ident_kind(input prefix_t p, input logic [TokWidth-1:0] len,
                                           input logic type_cand, input logic tail_digits);
    tok_kind_e k;
    k = TK_IDENT;
    if (len == TokWidth'(3) && p[0] == "l" && p[1] == "e" && p[2] == "t") begin
      k = TK_LET;
    end else if (len == TokWidth'(3) && p[0] == "m" && p[1] == "u" && p[2] == "t") begin
      k = TK_MUT;
    end else if (len == TokWidth'(2) && p[0] == "i" && p[1] == "f") begin
      k = TK_IF;
    end else if (len == TokWidth'(4) && p[0] == "e" && p[1] == "l" && p[2] == "s"
                 && p[3] == "e") begin
      k = TK_ELSE;
    end else if (len == TokWidth'(4) && p[0] == "e" && p[1] == "l" && p[2] == "i"
                 && p[3] == "f") begin
      k = TK_ELIF;
    end else if (len == TokWidth'(6) && p[0] == "u" && p[1] == "n" && p[2] == "s"
                 && p[3] == "a" && p[4] == "f" && p[5] == "e") begin
      k = TK_UNSAFE;
    end else if (type_cand && len > TokWidth'(1) && tail_digits) begin
      k = TK_TYPE;
    end
    return k;
  endfunction

endpackage

FILE: sv/sbt_if.sv
// ----------------------------------------------------------------------------
// sbt_in_if / sbt_out_if: valid/ready channels of the tokenizer
// Byte channel into the block and token channel out of it.
// ----------------------------------------------------------------------------
interface sbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_source;

  modport source (output valid, output ch, output end_of_source, input ready);
  modport sink   (input valid, input ch, input end_of_source, output ready);
endinterface

interface sbt_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic        last;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last, input ready);
  modport sink   (input valid, input token_kind, input token_start,
                  input token_length, input last, output ready);
endinterface

FILE: sv/sbt_front.sv
// ----------------------------------------------------------------------------
// sbt_front: scanner front end
// Accepts one byte a cycle while the queue is not full, tracks the pending
// token and pushes the tokens that each byte closes into the queue.
// ----------------------------------------------------------------------------
module sbt_front #(
  parameter int unsigned OFFSET_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  sbt_in_if.sink           in_i,
  input  logic             full_i,
  output logic             push_o,
  output sbt_pkg::entry_t  push_data_o
);
  import sbt_pkg::*;

  scan_mode_e              mode_q, mode_d;
  logic [TokWidth-1:0]     start_q, start_d;
  logic [TokWidth-1:0]     run_q, run_d;
  logic [OFFSET_WIDTH-1:0] offset_q, offset_d;
  prefix_t                 prefix_q, prefix_d;
  logic                    type_q, type_d;
  logic                    tail_q, tail_d;

  logic [TokWidth-1:0]     off16;
  logic                    accept;
  logic                    a_v, b_v;
  token_t                  tok_a, tok_b, flush_tok;
  logic [7:0]              c;

  // Start offsets are reported in 16 bits
  if (OFFSET_WIDTH >= TokWidth) begin : g_off_trunc
    assign off16 = offset_q[TokWidth-1:0];
  end else begin : g_off_ext
    assign off16 = {{(TokWidth-OFFSET_WIDTH){1'b0}}, offset_q};
  end

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign c          = in_i.ch;

  // Token that closes the pending run
  always_comb begin
    flush_tok.start = start_q;
    unique case (mode_q)
      MODE_IDENT: begin
        flush_tok.kind   = ident_kind(prefix_q, run_q, type_q, tail_q);
        flush_tok.length = run_q;
      end
      MODE_NUMBER: begin
        flush_tok.kind   = TK_NUMBER;
        flush_tok.length = run_q;
      end
      MODE_EQ: begin
        flush_tok.kind   = TK_ASSIGN;
        flush_tok.length = TokWidth'(1);
      end
      default: begin
        flush_tok.kind   = TK_EOF;
        flush_tok.length = '0;
      end
    endcase
  end

  // Scan one byte: extend, close and start tokens
  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    run_d    = run_q;
    offset_d = offset_q;
    prefix_d = prefix_q;
    type_d   = type_q;
    tail_d   = tail_q;
    a_v      = 1'b0;
    b_v      = 1'b0;
    tok_a    = flush_tok;
    tok_b    = '{kind: TK_EOF, start: off16, length: '0};

    if (accept) begin
      if (in_i.end_of_source) begin
        // Close the pending token, report end and clear all state
        a_v      = (mode_q != MODE_IDLE);
        b_v      = 1'b1;
        mode_d   = MODE_IDLE;
        start_d  = '0;
        run_d    = '0;
        offset_d = '0;
        prefix_d = '0;
        type_d   = 1'b0;
        tail_d   = 1'b1;
      end else begin
        offset_d = offset_q + OFFSET_WIDTH'(1);
        if ((mode_q == MODE_IDENT && (is_letter(c) || is_numeral(c)))
            || (mode_q == MODE_NUMBER && is_numeral(c))) begin
          // Extend the current run
          if (mode_q == MODE_IDENT) begin
            if (run_q < TokWidth'(PrefixDepth)) begin
              prefix_d[run_q[$clog2(PrefixDepth)-1:0]] = c;
            end
            if (!is_numeral(c)) begin
              tail_d = 1'b0;
            end
          end
          if (run_q != LenMax) begin
            run_d = run_q + TokWidth'(1);
          end
        end else if (mode_q == MODE_EQ && c == ChEqual) begin
          a_v          = 1'b1;
          tok_a.kind   = TK_EQ;
          tok_a.length = TokWidth'(2);
          mode_d       = MODE_IDLE;
        end else begin
          a_v    = (mode_q != MODE_IDLE);
          mode_d = MODE_IDLE;
          priority if (is_space(c)) begin
            mode_d = MODE_IDLE;
          end else if (is_letter(c)) begin
            mode_d      = MODE_IDENT;
            start_d     = off16;
            run_d       = TokWidth'(1);
            prefix_d    = '0;
            prefix_d[0] = c;
            type_d      = (c == "u" || c == "i");
            tail_d      = 1'b1;
          end else if (is_numeral(c)) begin
            mode_d  = MODE_NUMBER;
            start_d = off16;
            run_d   = TokWidth'(1);
          end else if (c == ChEqual) begin
            mode_d  = MODE_EQ;
            start_d = off16;
            run_d   = TokWidth'(1);
          end else begin
            b_v   = 1'b1;
            tok_b = '{kind: single_kind(c), start: off16, length: TokWidth'(1)};
          end
        end
      end
    end
  end

  // Pack the tokens of this byte in order
  always_comb begin
    push_o             = a_v || b_v;
    push_data_o.first  = a_v ? tok_a : tok_b;
    push_data_o.second = tok_b;
    push_data_o.two    = a_v && b_v;
  end

  // Hold scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      start_q  <= '0;
      run_q    <= '0;
      offset_q <= '0;
      prefix_q <= '0;
      type_q   <= 1'b0;
      tail_q   <= 1'b1;
    end else begin
      mode_q   <= mode_d;
      start_q  <= start_d;
      run_q    <= run_d;
      offset_q <= offset_d;
      prefix_q <= prefix_d;
      type_q   <= type_d;
      tail_q   <= tail_d;
    end
  end

endmodule

FILE: sv/sbt_queue.sv
// ----------------------------------------------------------------------------
// sbt_queue: token queue between scanner and output stage
// Small register FIFO of per-byte token entries.
// ----------------------------------------------------------------------------
module sbt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sbt_pkg::entry_t push_data_i,
  input  logic            pop_i,
  output sbt_pkg::entry_t pop_data_o,
  output logic            full_o,
  output logic            empty_o
);
  import sbt_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  entry_t            mem_q [QDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [PtrW:0]     cnt_q;

  assign full_o     = (cnt_q == (PtrW+1)'(QDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule

FILE: sv/sbt_back.sv
// ----------------------------------------------------------------------------
// sbt_back: token output stage
// Splits queue entries into single tokens and holds them in an output
// register until the sink takes them.
// ----------------------------------------------------------------------------
module sbt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sbt_pkg::entry_t pop_data_i,
  input  logic            empty_i,
  output logic            pop_o,
  sbt_out_if.source       out_o
);
  import sbt_pkg::*;

  logic   out_valid_q, out_last_q, pend_valid_q;
  token_t out_tok_q, pend_tok_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_o.ready;
  assign pop_o    = out_free && !pend_valid_q && !empty_i;

  assign out_o.valid        = out_valid_q;
  assign out_o.token_kind   = out_tok_q.kind;
  assign out_o.token_start  = out_tok_q.start;
  assign out_o.token_length = out_tok_q.length;
  assign out_o.last         = out_last_q;

  // Control: output valid and held second token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (out_free) begin
      if (pend_valid_q) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= !empty_i;
        pend_valid_q <= !empty_i && pop_data_i.two;
      end
    end
  end

  // Payload: load next token on each transfer
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_valid_q) begin
        out_tok_q  <= pend_tok_q;
        out_last_q <= 1'b1;
      end else begin
        out_tok_q  <= pop_data_i.first;
        out_last_q <= !pop_data_i.two;
        pend_tok_q <= pop_data_i.second;
      end
    end
  end

endmodule

FILE: sv/source_byte_tokenizer_top.sv
// ----------------------------------------------------------------------------
// source_byte_tokenizer_top: streaming lexer for source text
// Takes one byte per transfer and reports tokens with kind, start and length.
// ----------------------------------------------------------------------------
// The block takes one source byte per cycle while its four-entry token queue
// has room; each byte closes at most two tokens, which leave the output
// register one per cycle while the sink is ready, so the sustained rate is
// one byte per cycle except where a byte emits two tokens. A byte's first
// token is registered in the queue and then in the output register. An item
// with end_of_source set closes the pending token, emits eof and clears the
// offset counter, which otherwise wraps modulo 2^OFFSET_WIDTH.
module source_byte_tokenizer_top #(
  parameter int unsigned OFFSET_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sbt_in_if.sink    in_i,
  sbt_out_if.source out_o
);
  import sbt_pkg::*;

  logic   push, pop, full, empty;
  entry_t push_data, pop_data;

  sbt_front #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  sbt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (full),
    .empty_o     (empty)
  );

  sbt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_data_i (pop_data),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule
